FILE: rtl/nrmc_pkg.sv
`timescale 1ns / 1ps

package nrmc_pkg;

    // default field buffer capacity and offset after reset
    localparam int unsigned FIELD_CAPACITY_DEF = 16;
    localparam logic [3:0]  TZ_OFFSET_RST      = 4'd4;

    localparam int unsigned PHASE_W = 4;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_HUNT   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_G      = 4'd1;
    localparam logic [PHASE_W-1:0] PH_P      = 4'd2;
    localparam logic [PHASE_W-1:0] PH_R      = 4'd3;
    localparam logic [PHASE_W-1:0] PH_M      = 4'd4;
    localparam logic [PHASE_W-1:0] PH_C      = 4'd5;
    localparam logic [PHASE_W-1:0] PH_COMMA  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TIME   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_STATUS = 4'd8;
    localparam logic [PHASE_W-1:0] PH_SKIP   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_CK_HI  = 4'd10;
    localparam logic [PHASE_W-1:0] PH_CK_LO  = 4'd11;

    // characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] HEX_ADJ   = 8'h37;

    localparam int unsigned NUM_DIGITS = 6;

    typedef struct packed {
        logic [3:0] second_ones;
        logic [3:0] second_tens;
        logic [3:0] minute_ones;
        logic [3:0] minute_tens;
        logic [3:0] hour_ones;
        logic [3:0] hour_tens;
    } t_time;

    typedef struct packed {
        logic  valid;
        logic  fix_valid;
        t_time tm;
    } t_result;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               busy;
    } t_parse_stat;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = (c > CH_NINE) ? (c - HEX_ADJ) : c;
        return v[3:0];
    endfunction

endpackage

FILE: rtl/nmea_rmc_time_parser_top.sv
// a result word shows on m_axis in the cycle after the second checksum digit is taken
// throughput: one byte per cycle while s_axis_tready is high, set by the single parse stage and one output register
// s_axis_tready drops only while a result word is held and m_axis_tready is low
// reset (i_rst_n low, synchronous) returns to hunting for the start character,
// clears checksums, status and time digits, empties the output and sets the offset to 4
`timescale 1ns / 1ps

module nmea_rmc_time_parser_top
    import nrmc_pkg::*;
#(
    parameter int unsigned FIELD_CAPACITY = FIELD_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,    // time_zone_offset
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // MSB first: second_ones, second_tens, minute_ones, minute_tens, hour_ones, hour_tens
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tuser    // fix_valid
);

    logic [3:0]  r_tz_offset;
    logic        accept;
    t_result     result;
    t_parse_stat stat;
    t_time       out_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz_offset <= TZ_OFFSET_RST;
        end else if (i_cfg_we) begin
            r_tz_offset <= i_cfg_wdata;
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    nrmc_parser #(
        .FIELD_CAPACITY (FIELD_CAPACITY)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_tz     (r_tz_offset),
        .o_result (result),
        .o_stat   (stat)
    );

    nrmc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_time      (out_time),
        .o_fix_valid (m_axis_tuser)
    );

    assign m_axis_tdata = {out_time.second_ones, out_time.second_tens,
                           out_time.minute_ones, out_time.minute_tens,
                           out_time.hour_ones, out_time.hour_tens};

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // a result is only produced from the last checksum digit
    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.valid |-> (stat.phase == PH_CK_LO))
        else $error("result outside checksum phase");

    // after a result the parser is back to hunting
    a_emit_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.valid |=> (stat.phase == PH_HUNT) && !stat.busy)
        else $error("parser not hunting after result");

    // a new result always lands in the output register
    a_emit_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.valid |=> m_axis_tvalid)
        else $error("result word lost");

endmodule

FILE: rtl/nrmc_hour_conv.sv
`timescale 1ns / 1ps

module nrmc_hour_conv
    import nrmc_pkg::*;
(
    input  logic [3:0] i_tens,
    input  logic [3:0] i_ones,
    input  logic [3:0] i_tz,
    output logic [3:0] o_tens,
    output logic [3:0] o_ones
);

    // 9-bit two's complement covers -15..165, bit 8 marks a negative result
    logic [8:0] h_raw;
    logic [8:0] h_wrap;
    logic [8:0] h_add;
    logic [8:0] h_sub;
    logic [8:0] h_m10;
    logic       big;

    always_comb begin
        h_raw  = 9'(i_tens) * 9'd10 + 9'(i_ones);
        h_wrap = (h_raw > 9'd12) ? (h_raw - 9'd12) : h_raw;
        h_add  = (h_wrap <= 9'(i_tz)) ? (h_wrap + 9'd12) : h_wrap;
        h_sub  = h_add - 9'(i_tz);
        h_m10  = h_sub - 9'd10;
        // negative wraps to a huge unsigned value, so it counts as above nine
        big    = h_sub[8] || (h_sub > 9'd9);
        o_tens = big ? 4'd1 : 4'd0;
        o_ones = big ? h_m10[3:0] : h_sub[3:0];
    end

endmodule

FILE: rtl/nrmc_parser.sv
`timescale 1ns / 1ps

module nrmc_parser
    import nrmc_pkg::*;
#(
    parameter int unsigned FIELD_CAPACITY = FIELD_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [3:0]  i_tz,
    output t_result     o_result,
    output t_parse_stat o_stat
);

    localparam int unsigned CW = $clog2(FIELD_CAPACITY + 1);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CW-1:0]      r_count, n_count;
    logic [7:0]         r_xor, n_xor;
    logic [7:0]         r_captured, n_captured;
    logic [3:0]         r_recv_hi, n_recv_hi;
    logic               r_status, n_status;
    logic [3:0]         r_digits [NUM_DIGITS];
    logic [3:0]         n_digits [NUM_DIGITS];

    logic [7:0] xor_upd;
    logic [3:0] conv_tens;
    logic [3:0] conv_ones;
    logic       emit;

    nrmc_hour_conv u_hour_conv (
        .i_tens (r_digits[0]),
        .i_ones (r_digits[1]),
        .i_tz   (i_tz),
        .o_tens (conv_tens),
        .o_ones (conv_ones)
    );

    always_comb begin
        xor_upd    = (i_byte != CH_STAR) ? (r_xor ^ i_byte) : r_xor;
        n_phase    = r_phase;
        n_count    = r_count;
        n_xor      = xor_upd;
        n_captured = r_captured;
        n_recv_hi  = r_recv_hi;
        n_status   = r_status;
        emit       = 1'b0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            n_digits[k] = r_digits[k];
        end

        unique case (r_phase)
            PH_HUNT: begin
                n_phase = (i_byte == CH_DOLLAR) ? PH_G : PH_HUNT;
                n_xor   = 8'd0;
            end
            PH_G:    n_phase = (i_byte == CH_G) ? PH_P : PH_HUNT;
            PH_P:    n_phase = (i_byte == CH_P) ? PH_R : PH_HUNT;
            PH_R:    n_phase = (i_byte == CH_R) ? PH_M : PH_HUNT;
            PH_M:    n_phase = (i_byte == CH_M) ? PH_C : PH_HUNT;
            PH_C:    n_phase = (i_byte == CH_C) ? PH_COMMA : PH_HUNT;
            PH_COMMA: begin
                n_count = '0;
                n_phase = (i_byte == CH_COMMA) ? PH_TIME : PH_HUNT;
            end
            PH_TIME: begin
                if (i_byte == CH_COMMA) begin
                    // a time field of eight or more characters (as hhmmss.ss) gets the local time conversion
                    if (r_count > CW'(7)) begin
                        n_digits[0] = conv_tens;
                        n_digits[1] = conv_ones;
                    end
                    n_count = '0;
                    n_phase = PH_STATUS;
                end else if (r_count < CW'(FIELD_CAPACITY)) begin
                    for (int k = 0; k < NUM_DIGITS; k++) begin
                        if (r_count == CW'(k)) begin
                            n_digits[k] = i_byte[3:0];
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            PH_STATUS, PH_SKIP: begin
                if (r_phase == PH_STATUS) begin
                    n_status = (i_byte == CH_A);
                    n_phase  = PH_SKIP;
                end
                if (i_byte == CH_STAR) begin
                    n_captured = xor_upd;
                    n_phase    = PH_CK_HI;
                end
            end
            PH_CK_HI: begin
                n_recv_hi = hex_nibble(i_byte);
                n_phase   = PH_CK_LO;
            end
            PH_CK_LO: begin
                emit = ({r_recv_hi, hex_nibble(i_byte)} == r_captured);
                for (int k = 0; k < NUM_DIGITS; k++) begin
                    n_digits[k] = 4'd0;
                end
                n_phase = PH_HUNT;
            end
            default: n_phase = PH_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_count    <= '0;
            r_xor      <= 8'd0;
            r_captured <= 8'd0;
            r_recv_hi  <= 4'd0;
            r_status   <= 1'b0;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_digits[k] <= 4'd0;
            end
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_xor      <= n_xor;
            r_captured <= n_captured;
            r_recv_hi  <= n_recv_hi;
            r_status   <= n_status;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_digits[k] <= n_digits[k];
            end
        end
    end

    assign o_result.valid          = i_accept && emit;
    assign o_result.fix_valid      = r_status;
    assign o_result.tm.hour_tens   = r_digits[0];
    assign o_result.tm.hour_ones   = r_digits[1];
    assign o_result.tm.minute_tens = r_digits[2];
    assign o_result.tm.minute_ones = r_digits[3];
    assign o_result.tm.second_tens = r_digits[4];
    assign o_result.tm.second_ones = r_digits[5];

    assign o_stat.phase = r_phase;
    assign o_stat.busy  = (r_phase != PH_HUNT);

endmodule

FILE: rtl/nrmc_out_reg.sv
`timescale 1ns / 1ps

module nrmc_out_reg
    import nrmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_time   o_time,
    output logic    o_fix_valid
);

    logic  r_valid;
    t_time r_time;
    logic  r_fix;

    // room for a new word when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_time <= i_result.tm;
            r_fix  <= i_result.fix_valid;
        end
    end

    assign o_valid     = r_valid;
    assign o_time      = r_time;
    assign o_fix_valid = r_fix;

endmodule
